FILE: hdl/fiir_pkg.sv
// shared types, widths and microprogram of the first-order iir band filter
package fiir_pkg;

  localparam int SampleBits    = 24;
  localparam int CoefFracBits  = 16;
  localparam int StateFracBits = 8;

  localparam int DiffW   = SampleBits + 1;
  localparam int StateW  = SampleBits + StateFracBits;
  localparam int GainW   = CoefFracBits + 1;
  localparam int PoleW   = CoefFracBits + 2;
  localparam int MulBW   = (StateW > DiffW) ? StateW : DiffW;
  localparam int ProdW   = PoleW + MulBW;
  localparam int AccW    = ProdW + StateFracBits + 1;
  localparam int OutRndW = StateW + 1;

  localparam int ModeW   = 2;
  localparam int RegIdxW = 3;
  localparam int AddrW   = RegIdxW + 2;
  localparam int DataW   = 32;
  localparam int StepW   = 4;

  // any other mode code runs bandpass
  localparam logic [ModeW-1:0] ModeLowpass  = 2'd0;
  localparam logic [ModeW-1:0] ModeHighpass = 2'd1;

  typedef enum logic [RegIdxW-1:0] {
    REG_MODE    = 3'd0,
    REG_LP_GAIN = 3'd1,
    REG_LP_POLE = 3'd2,
    REG_HP_GAIN = 3'd3,
    REG_HP_POLE = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample_in;
    logic                         record_start;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample_out;
    logic                         clipped;
  } out_item_t;

  typedef enum logic [2:0] {
    UOP_NOP   = 3'd0,
    UOP_MUL_G = 3'd1,
    UOP_MUL_P = 3'd2,
    UOP_ACC   = 3'd3,
    UOP_RND   = 3'd4,
    UOP_OUT   = 3'd5,
    UOP_SEED  = 3'd6,
    UOP_DONE  = 3'd7
  } uop_e;

  typedef enum logic {
    SEC_LP = 1'b0,
    SEC_HP = 1'b1
  } sec_e;

  typedef enum logic [2:0] {
    JC_NONE    = 3'd0,
    JC_START   = 3'd1,
    JC_HP_ONLY = 3'd2,
    JC_LP_ONLY = 3'd3,
    JC_ALWAYS  = 3'd4
  } jcond_e;

  typedef struct packed {
    uop_e             op;
    sec_e             sec;
    jcond_e           jc;
    logic [StepW-1:0] target;
  } ucode_t;

  localparam logic [StepW-1:0] StepHpFirst = 4'd7;
  localparam logic [StepW-1:0] StepSeed    = 4'd12;
  localparam logic [StepW-1:0] StepDone    = 4'd13;

  function automatic ucode_t ucode_rom(logic [StepW-1:0] step);
    ucode_t w;
    unique case (step)
      4'd0:    w = '{UOP_NOP,   SEC_LP, JC_START,   StepSeed};
      4'd1:    w = '{UOP_NOP,   SEC_LP, JC_HP_ONLY, StepHpFirst};
      4'd2:    w = '{UOP_MUL_G, SEC_LP, JC_NONE,    StepDone};
      4'd3:    w = '{UOP_MUL_P, SEC_LP, JC_NONE,    StepDone};
      4'd4:    w = '{UOP_ACC,   SEC_LP, JC_NONE,    StepDone};
      4'd5:    w = '{UOP_RND,   SEC_LP, JC_NONE,    StepDone};
      4'd6:    w = '{UOP_OUT,   SEC_LP, JC_LP_ONLY, StepDone};
      4'd7:    w = '{UOP_MUL_G, SEC_HP, JC_NONE,    StepDone};
      4'd8:    w = '{UOP_MUL_P, SEC_HP, JC_NONE,    StepDone};
      4'd9:    w = '{UOP_ACC,   SEC_HP, JC_NONE,    StepDone};
      4'd10:   w = '{UOP_RND,   SEC_HP, JC_NONE,    StepDone};
      4'd11:   w = '{UOP_OUT,   SEC_HP, JC_ALWAYS,  StepDone};
      4'd12:   w = '{UOP_SEED,  SEC_LP, JC_NONE,    StepDone};
      default: w = '{UOP_DONE,  SEC_LP, JC_NONE,    StepDone};
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/first_order_iir_band_filter_top.sv
// top level: microcoded first-order iir lowpass / highpass / bandpass filter
// one request at a time; lowpass or highpass runs one section, bandpass runs the
// lowpass then the highpass section, and a record start only seeds the state
// in_ready returns as the result is loaded, so no new sample is taken before then
// the microprogram steps through one shared 18x32 multiplier, two products per section
// rst_ni clears config registers, filter state and handshake control asynchronously
module first_order_iir_band_filter_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  fiir_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output fiir_pkg::out_item_t                 out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fiir_pkg::AddrW-1:0]          paddr,
  input  logic [fiir_pkg::DataW-1:0]          pwdata,
  output logic [fiir_pkg::DataW-1:0]          prdata,
  output logic                                pready
);
  import fiir_pkg::*;

  localparam logic signed [AccW-1:0] YHi = (AccW'(1) << (StateW - 1)) - AccW'(1);
  localparam logic signed [AccW-1:0] YLo = -(AccW'(1) << (StateW - 1));
  localparam logic signed [OutRndW-1:0] SMax =
    (OutRndW'(1) << (SampleBits - 1)) - OutRndW'(1);

  // configuration registers
  logic [ModeW-1:0]        mode_q;
  logic [GainW-1:0]        lp_gain_q, hp_gain_q;
  logic signed [PoleW-1:0] lp_pole_q, hp_pole_q;
  logic                    cfg_wr;
  reg_idx_e                reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= '0;
      lp_gain_q <= '0;
      lp_pole_q <= '0;
      hp_gain_q <= '0;
      hp_pole_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MODE:    mode_q    <= pwdata[ModeW-1:0];
        REG_LP_GAIN: lp_gain_q <= pwdata[GainW-1:0];
        REG_LP_POLE: lp_pole_q <= pwdata[PoleW-1:0];
        REG_HP_GAIN: hp_gain_q <= pwdata[GainW-1:0];
        REG_HP_POLE: hp_pole_q <= pwdata[PoleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:    prdata = DataW'(mode_q);
      REG_LP_GAIN: prdata = DataW'(lp_gain_q);
      REG_LP_POLE: prdata = DataW'(lp_pole_q);
      REG_HP_GAIN: prdata = DataW'(hp_gain_q);
      REG_HP_POLE: prdata = DataW'(hp_pole_q);
      default:     prdata = '0;
    endcase
  end

  // sequencer
  logic             busy_q;
  logic [StepW-1:0] step_q, step_d;
  ucode_t           uc;
  logic             in_acc, done_step, out_free, finish, take;

  assign uc         = ucode_rom(step_q);
  assign in_ready_o = !busy_q;
  assign in_acc     = in_valid_i & in_ready_o;
  assign done_step  = busy_q && (uc.op == UOP_DONE);
  assign out_free   = !out_valid_o || out_ready_i;
  assign finish     = done_step && out_free;

  // datapath registers
  logic signed [SampleBits-1:0] sec_x_q;
  logic                         start_q, clip_q;
  logic signed [ProdW-1:0]      prod_q;
  logic signed [AccW-1:0]       acc_q;
  logic signed [SampleBits-1:0] lp_in_q, hp_in_q;
  logic signed [StateW-1:0]     lp_out_q, hp_out_q;
  out_item_t                    out_data_q;
  logic                         out_valid_q;

  always_comb begin
    unique case (uc.jc)
      JC_NONE:    take = 1'b0;
      JC_START:   take = start_q;
      JC_HP_ONLY: take = (mode_q == ModeHighpass);
      JC_LP_ONLY: take = (mode_q == ModeLowpass);
      JC_ALWAYS:  take = 1'b1;
      default:    take = 1'b0;
    endcase
  end

  always_comb begin
    priority if (in_acc) begin
      step_d = '0;
    end else if (busy_q && !done_step) begin
      step_d = take ? uc.target : step_q + StepW'(1);
    end else begin
      step_d = step_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      step_q <= step_d;
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
    end
  end

  // section operand selection and shared multiplier
  logic signed [SampleBits-1:0] sel_in;
  logic signed [StateW-1:0]     sel_out;
  logic [GainW-1:0]             sel_gain;
  logic signed [PoleW-1:0]      sel_pole;
  logic signed [DiffW-1:0]      diff;
  logic signed [PoleW-1:0]      mul_a;
  logic signed [MulBW-1:0]      mul_b;
  logic signed [ProdW-1:0]      prod;

  assign sel_in   = (uc.sec == SEC_HP) ? hp_in_q   : lp_in_q;
  assign sel_out  = (uc.sec == SEC_HP) ? hp_out_q  : lp_out_q;
  assign sel_gain = (uc.sec == SEC_HP) ? hp_gain_q : lp_gain_q;
  assign sel_pole = (uc.sec == SEC_HP) ? hp_pole_q : lp_pole_q;
  assign diff     = (uc.sec == SEC_HP) ? DiffW'(sec_x_q) - DiffW'(sel_in)
                                       : DiffW'(sec_x_q) + DiffW'(sel_in);
  assign mul_a    = (uc.op == UOP_MUL_G) ? signed'({1'b0, sel_gain}) : sel_pole;
  assign mul_b    = (uc.op == UOP_MUL_G) ? MulBW'(diff) : MulBW'(sel_out);
  assign prod     = ProdW'(mul_a) * ProdW'(mul_b);

  // accumulate, round half up and saturate the state
  logic signed [AccW-1:0]    acc_seed, acc_sub, acc_rnd, y_full;
  logic signed [StateW-1:0]  y_sat;
  logic                      y_clip;

  assign acc_seed = AccW'(prod_q) <<< StateFracBits;
  assign acc_sub  = acc_q - AccW'(prod_q);
  assign acc_rnd  = acc_q + (AccW'(1) << (CoefFracBits - 1));
  assign y_full   = acc_rnd >>> CoefFracBits;

  always_comb begin
    priority if (y_full > YHi) begin
      y_sat  = StateW'(YHi);
      y_clip = 1'b1;
    end else if (y_full < YLo) begin
      y_sat  = StateW'(YLo);
      y_clip = 1'b1;
    end else begin
      y_sat  = StateW'(y_full);
      y_clip = 1'b0;
    end
  end

  // section output from the stored state
  logic signed [OutRndW-1:0]    o_rnd, o_full;
  logic signed [SampleBits-1:0] o_val;
  logic                         o_clip;

  assign o_rnd  = OutRndW'(sel_out) + (OutRndW'(1) << (StateFracBits - 1));
  assign o_full = o_rnd >>> StateFracBits;
  assign o_clip = (o_full > SMax);
  assign o_val  = o_clip ? SMax[SampleBits-1:0] : o_full[SampleBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_in_q  <= '0;
      lp_out_q <= '0;
      hp_in_q  <= '0;
      hp_out_q <= '0;
    end else if (busy_q) begin
      unique case (uc.op)
        UOP_RND: begin
          if (uc.sec == SEC_HP) begin
            hp_in_q  <= sec_x_q;
            hp_out_q <= y_sat;
          end else begin
            lp_in_q  <= sec_x_q;
            lp_out_q <= y_sat;
          end
        end
        UOP_SEED: begin
          lp_in_q  <= sec_x_q;
          hp_in_q  <= sec_x_q;
          lp_out_q <= {sec_x_q, {StateFracBits{1'b0}}};
          hp_out_q <= {sec_x_q, {StateFracBits{1'b0}}};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sec_x_q <= in_data_i.sample_in;
      start_q <= in_data_i.record_start;
      clip_q  <= 1'b0;
    end else if (busy_q) begin
      unique case (uc.op)
        UOP_MUL_G: prod_q <= prod;
        UOP_MUL_P: begin
          prod_q <= prod;
          acc_q  <= acc_seed;
        end
        UOP_ACC:   acc_q  <= acc_sub;
        UOP_RND:   clip_q <= clip_q | y_clip;
        UOP_OUT: begin
          // section result becomes the next section's input and the final sample
          sec_x_q <= o_val;
          clip_q  <= clip_q | o_clip;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_data_q.sample_out <= sec_x_q;
      out_data_q.clipped    <= clip_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: hdl/fiir_checker.sv
// port-level checks of the filter top, bound to every instance
module fiir_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input fiir_pkg::out_item_t         out_data_o,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [fiir_pkg::AddrW-1:0]  paddr,
  input logic [fiir_pkg::DataW-1:0]  pwdata,
  input logic [fiir_pkg::DataW-1:0]  prdata,
  input logic                        pready
);
  import fiir_pkg::*;

  logic cfg_wr;
  logic mode_addr;

  assign cfg_wr    = psel && penable && pwrite && pready;
  assign mode_addr = (paddr[AddrW-1:2] == REG_MODE);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // one sample in flight: a request closes the input until its result is loaded
  a_single_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input still open right after a request");

  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without a sample in work");

  a_mode_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cfg_wr) && $past(mode_addr) && mode_addr |->
      prdata == DataW'($past(pwdata[ModeW-1:0])))
    else $error("mode register does not read back the written value");

endmodule

bind first_order_iir_band_filter_top fiir_checker u_fiir_checker (.*);
